[src/bts_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear texture sampler package
// Shared constants, status and request codes, and the structures that pass
// between the request front end, the memory sequencer and the blend pipeline.
// ----------------------------------------------------------------------------
package bts_pkg;

    // Texture geometry and coordinate format.
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int FRAC_BITS  = 16;

    localparam int XW        = $clog2(MAX_WIDTH);
    localparam int YW        = $clog2(MAX_HEIGHT);
    localparam int ADDR_W    = XW + YW;
    localparam int TEX_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    // Register and field widths.
    localparam int SIZE_W    = 9;
    localparam int COORD_W   = 18;
    localparam int CHAN_W    = 8;
    localparam int NUM_CH    = 3;
    localparam int TEXEL_W   = NUM_CH * CHAN_W;
    localparam int SAMPLE_W  = 16;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;

    // Datapath widths for the separable blend.
    localparam int WEIGHT_W = FRAC_BITS + 1;
    localparam int ROW_W    = CHAN_W + FRAC_BITS;
    localparam int ACC_W    = ROW_W + FRAC_BITS;
    localparam int OUT_LSB  = 2 * FRAC_BITS - CHAN_W;

    localparam logic [WEIGHT_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Reset value of both size registers.
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

    // Four neighbor reads per sample.
    localparam int                  READS_PER_SAMPLE = 4;
    localparam int                  STEP_W           = $clog2(READS_PER_SAMPLE);
    localparam logic [STEP_W-1:0]   STEP_LAST        = STEP_W'(READS_PER_SAMPLE - 1);

    // Result queue sizing.
    localparam int RESULT_DEPTH = 8;
    localparam int RESULT_PTR_W = $clog2(RESULT_DEPTH);
    localparam int CREDIT_W     = RESULT_PTR_W + 1;

    // Request types.
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_COORD = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ADDR  = 2'd2;

    // Decoded request handed from the front end to the sequencer.
    typedef struct packed {
        logic                  sample;
        logic [STATUS_W-1:0]   status;
        logic [XW-1:0]         x;
        logic [YW-1:0]         y;
        logic [FRAC_BITS-1:0]  fx;
        logic [FRAC_BITS-1:0]  fy;
        logic [TEXEL_W-1:0]    texel;
    } job_t;

    // One memory slot worth of work handed to the blend pipeline.
    typedef struct packed {
        logic                  last;
        logic                  blend;
        logic [STATUS_W-1:0]   status;
        logic                  col;
        logic                  row;
        logic [WEIGHT_W-1:0]   wx;
        logic [WEIGHT_W-1:0]   wy;
    } token_t;

    // One finished result.
    typedef struct packed {
        logic [SAMPLE_W-1:0]   red;
        logic [SAMPLE_W-1:0]   green;
        logic [SAMPLE_W-1:0]   blue;
        logic [STATUS_W-1:0]   status;
    } result_t;

endpackage
`default_nettype wire

[src/bts_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, either a write or a read; read data is registered.
// ----------------------------------------------------------------------------
module bts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write or registered read on the single port.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_array[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_array[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[src/bts_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear texture sampler front end
// Holds the size registers, registers each request transaction, checks it and
// scales sample coordinates into a texel position and fraction.
// ----------------------------------------------------------------------------
module bts_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    input  wire logic [bts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [bts_pkg::SIZE_W-1:0]          cfg_data,
    input  wire logic                                req_valid,
    output logic                                     req_stall,
    input  wire logic                                req_type,
    input  wire logic [bts_pkg::XW-1:0]              texel_x,
    input  wire logic [bts_pkg::YW-1:0]              texel_y,
    input  wire logic [bts_pkg::CHAN_W-1:0]          texel_red,
    input  wire logic [bts_pkg::CHAN_W-1:0]          texel_green,
    input  wire logic [bts_pkg::CHAN_W-1:0]          texel_blue,
    input  wire logic signed [bts_pkg::COORD_W-1:0]  coord_u,
    input  wire logic signed [bts_pkg::COORD_W-1:0]  coord_v,
    output logic                                     job_valid,
    output bts_pkg::job_t                            job,
    input  wire logic                                job_take
);

    localparam int PX_W = bts_pkg::WEIGHT_W + bts_pkg::XW;
    localparam int PY_W = bts_pkg::WEIGHT_W + bts_pkg::YW;
    localparam logic signed [bts_pkg::COORD_W-1:0] COORD_ONE =
        bts_pkg::COORD_W'(bts_pkg::ONE);

    // Size registers.
    logic [bts_pkg::SIZE_W-1:0] tex_width_reg;
    logic [bts_pkg::SIZE_W-1:0] tex_height_reg;

    // Input stage.
    logic                               s0_valid_reg;
    logic                               s0_valid_next;
    logic                               s0_type_reg;
    logic [bts_pkg::XW-1:0]             s0_x_reg;
    logic [bts_pkg::YW-1:0]             s0_y_reg;
    logic [bts_pkg::TEXEL_W-1:0]        s0_texel_reg;
    logic signed [bts_pkg::COORD_W-1:0] s0_u_reg;
    logic signed [bts_pkg::COORD_W-1:0] s0_v_reg;

    // Decoded stage.
    logic          s1_valid_reg;
    logic          s1_valid_next;
    bts_pkg::job_t job_reg;
    bts_pkg::job_t job_next;

    logic req_accept;
    logic s1_free;
    logic s0_move;

    logic [bts_pkg::SIZE_W-1:0]   w_eff;
    logic [bts_pkg::SIZE_W-1:0]   h_eff;
    logic [bts_pkg::XW-1:0]       w_m1;
    logic [bts_pkg::YW-1:0]       h_m1;
    logic                         u_bad;
    logic                         v_bad;
    logic                         x_bad;
    logic                         y_bad;
    logic [bts_pkg::WEIGHT_W-1:0] u_mag;
    logic [bts_pkg::WEIGHT_W-1:0] v_flip;
    logic [PX_W-1:0]              px;
    logic [PY_W-1:0]              py;

    // Handshake between the input stage and the decoded stage.
    assign s1_free    = !s1_valid_reg || job_take;
    assign s0_move    = s0_valid_reg && s1_free;
    assign req_stall  = s0_valid_reg && !s1_free;
    assign req_accept = req_valid && !req_stall;

    assign s0_valid_next = req_accept || (s0_valid_reg && !s1_free);
    assign s1_valid_next = s0_move || (s1_valid_reg && !job_take);

    // Effective sizes: zero acts as one, anything above the maximum is clamped.
    always_comb
    begin
        if (tex_width_reg == '0)
        begin
            w_eff = bts_pkg::SIZE_W'(1);
        end
        else if (tex_width_reg > bts_pkg::SIZE_W'(bts_pkg::MAX_WIDTH))
        begin
            w_eff = bts_pkg::SIZE_W'(bts_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = tex_width_reg;
        end

        if (tex_height_reg == '0)
        begin
            h_eff = bts_pkg::SIZE_W'(1);
        end
        else if (tex_height_reg > bts_pkg::SIZE_W'(bts_pkg::MAX_HEIGHT))
        begin
            h_eff = bts_pkg::SIZE_W'(bts_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = tex_height_reg;
        end
    end

    assign w_m1 = bts_pkg::XW'(w_eff - bts_pkg::SIZE_W'(1));
    assign h_m1 = bts_pkg::YW'(h_eff - bts_pkg::SIZE_W'(1));

    // Range checks for both request types.
    assign u_bad = s0_u_reg[bts_pkg::COORD_W-1] || (s0_u_reg > COORD_ONE);
    assign v_bad = s0_v_reg[bts_pkg::COORD_W-1] || (s0_v_reg > COORD_ONE);
    assign x_bad = bts_pkg::SIZE_W'(s0_x_reg) >= w_eff;
    assign y_bad = bts_pkg::SIZE_W'(s0_y_reg) >= h_eff;

    // Scale u and the flipped v by size minus one.
    assign u_mag  = s0_u_reg[bts_pkg::FRAC_BITS:0];
    assign v_flip = bts_pkg::ONE - s0_v_reg[bts_pkg::FRAC_BITS:0];
    assign px     = PX_W'(u_mag) * PX_W'(w_m1);
    assign py     = PY_W'(v_flip) * PY_W'(h_m1);

    // Build the decoded request.
    always_comb
    begin
        job_next       = '0;
        job_next.texel = s0_texel_reg;
        if (s0_type_reg == bts_pkg::REQ_SAMPLE)
        begin
            if (u_bad || v_bad)
            begin
                job_next.status = bts_pkg::STATUS_COORD;
            end
            else
            begin
                job_next.sample = 1'b1;
                job_next.status = bts_pkg::STATUS_OK;
                job_next.x      = px[bts_pkg::FRAC_BITS +: bts_pkg::XW];
                job_next.y      = py[bts_pkg::FRAC_BITS +: bts_pkg::YW];
                job_next.fx     = px[bts_pkg::FRAC_BITS-1:0];
                job_next.fy     = py[bts_pkg::FRAC_BITS-1:0];
            end
        end
        else
        begin
            job_next.x = s0_x_reg;
            job_next.y = s0_y_reg;
            if (x_bad || y_bad)
            begin
                job_next.status = bts_pkg::STATUS_ADDR;
            end
            else
            begin
                job_next.status = bts_pkg::STATUS_OK;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= bts_pkg::SIZE_RESET;
            tex_height_reg <= bts_pkg::SIZE_RESET;
            s0_valid_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    bts_pkg::CFG_WIDTH:  tex_width_reg  <= cfg_data;
                    bts_pkg::CFG_HEIGHT: tex_height_reg <= cfg_data;
                endcase
            end
            s0_valid_reg <= s0_valid_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s0_type_reg  <= req_type;
            s0_x_reg     <= texel_x;
            s0_y_reg     <= texel_y;
            s0_texel_reg <= {texel_red, texel_green, texel_blue};
            s0_u_reg     <= coord_u;
            s0_v_reg     <= coord_v;
        end
        if (s0_move)
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = s1_valid_reg;
    assign job       = job_reg;

endmodule
`default_nettype wire

[src/bts_issue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear texture sampler memory sequencer
// Drives the texel memory port: one write per in-range texel write, four neighbor
// reads per valid sample, and a token per slot for the blend pipeline. Starts a
// request only when the result queue has a free place for it.
// ----------------------------------------------------------------------------
module bts_issue (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           job_valid,
    input  wire bts_pkg::job_t                  job,
    output logic                                job_take,
    input  wire logic                           rsp_done,
    output logic                                mem_en,
    output logic                                mem_we,
    output logic [bts_pkg::ADDR_W-1:0]          mem_addr,
    output logic [bts_pkg::TEXEL_W-1:0]         mem_wdata,
    output logic                                token_valid,
    output bts_pkg::token_t                     token
);

    logic [bts_pkg::STEP_W-1:0]   step_reg;
    logic [bts_pkg::STEP_W-1:0]   step_next;
    logic [bts_pkg::CREDIT_W-1:0] credit_reg;
    logic [bts_pkg::CREDIT_W-1:0] credit_next;

    logic                         first;
    logic                         credit_ok;
    logic                         issue;
    logic                         last_step;
    logic                         col;
    logic                         row;
    logic                         write_ok;
    logic [bts_pkg::XW-1:0]       x2;
    logic [bts_pkg::YW-1:0]       y2;
    logic [bts_pkg::XW-1:0]       x_sel;
    logic [bts_pkg::YW-1:0]       y_sel;
    logic [bts_pkg::WEIGHT_W-1:0] fx_w;
    logic [bts_pkg::WEIGHT_W-1:0] fy_w;

    // Slot control: a new request needs a reserved place in the result queue.
    assign first     = step_reg == '0;
    assign credit_ok = credit_reg < bts_pkg::CREDIT_W'(bts_pkg::RESULT_DEPTH);
    assign issue     = job_valid && (!first || credit_ok);
    assign last_step = !job.sample || (step_reg == bts_pkg::STEP_LAST);
    assign job_take  = issue && last_step;
    assign write_ok  = !job.sample && (job.status == bts_pkg::STATUS_OK);

    // Neighbor selection: the upper neighbor exists only for a nonzero fraction.
    assign col   = step_reg[0];
    assign row   = step_reg[1];
    assign x2    = job.x + bts_pkg::XW'(job.fx != '0);
    assign y2    = job.y + bts_pkg::YW'(job.fy != '0);
    assign x_sel = col ? x2 : job.x;
    assign y_sel = row ? y2 : job.y;

    // Memory port.
    assign mem_en    = issue && (job.sample || write_ok);
    assign mem_we    = issue && write_ok;
    assign mem_addr  = {y_sel, x_sel};
    assign mem_wdata = job.texel;

    // Token with the axis weights of this neighbor.
    assign fx_w = {1'b0, job.fx};
    assign fy_w = {1'b0, job.fy};

    always_comb
    begin
        token        = '0;
        token.last   = last_step;
        token.blend  = job.sample;
        token.status = job.status;
        token.col    = col;
        token.row    = row;
        token.wx     = col ? fx_w : (bts_pkg::ONE - fx_w);
        token.wy     = row ? fy_w : (bts_pkg::ONE - fy_w);
    end

    assign token_valid = issue;

    // Step counter and result credit.
    always_comb
    begin
        step_next = step_reg;
        if (issue)
        begin
            step_next = last_step ? '0 : step_reg + bts_pkg::STEP_W'(1);
        end
        credit_next = credit_reg + bts_pkg::CREDIT_W'(issue && first)
                    - bts_pkg::CREDIT_W'(rsp_done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            credit_reg <= '0;
        end
        else
        begin
            step_reg   <= step_next;
            credit_reg <= credit_next;
        end
    end

`ifndef SYNTHESIS
    // Outstanding results never exceed the result queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= bts_pkg::CREDIT_W'(bts_pkg::RESULT_DEPTH))
    else $error("result credit above queue depth");

    // A sample in progress keeps its request until the last neighbor read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != '0) |-> (job_valid && job.sample))
    else $error("request lost in the middle of a sample");

    // A texel write always takes the first slot of a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (first && job_take))
    else $error("texel write outside the first slot");
`endif

endmodule
`default_nettype wire

[src/bts_blend.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear texture sampler blend pipeline
// Blends the four neighbors separably: each row is weighted along x, the two
// row sums are weighted along y, and the result is queued for the output.
// ----------------------------------------------------------------------------
module bts_blend (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          token_valid,
    input  wire bts_pkg::token_t               token,
    input  wire logic [bts_pkg::TEXEL_W-1:0]   mem_rdata,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic [bts_pkg::SAMPLE_W-1:0]       sample_red,
    output logic [bts_pkg::SAMPLE_W-1:0]       sample_green,
    output logic [bts_pkg::SAMPLE_W-1:0]       sample_blue,
    output logic [bts_pkg::STATUS_W-1:0]       status,
    output logic                               rsp_done
);

    localparam int PRODX_W = bts_pkg::CHAN_W + bts_pkg::WEIGHT_W;
    localparam int CH_RED   = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 0;

    // Pipeline tokens.
    logic            t1_valid_reg;
    bts_pkg::token_t t1_reg;
    logic            t2_valid_reg;
    bts_pkg::token_t t2_reg;
    logic            t3_valid_reg;
    logic            t3_valid_next;
    bts_pkg::token_t t3_reg;
    logic            t4_valid_reg;
    bts_pkg::token_t t4_reg;

    // Per channel datapath.
    logic [bts_pkg::ROW_W-1:0] prodx      [bts_pkg::NUM_CH];
    logic [bts_pkg::ROW_W-1:0] px_reg     [bts_pkg::NUM_CH];
    logic [bts_pkg::ROW_W-1:0] rowacc_reg [bts_pkg::NUM_CH];
    logic [bts_pkg::ROW_W-1:0] rowsum_reg [bts_pkg::NUM_CH];
    logic [bts_pkg::ACC_W-1:0] prody      [bts_pkg::NUM_CH];
    logic [bts_pkg::ACC_W-1:0] py_reg     [bts_pkg::NUM_CH];
    logic [bts_pkg::ACC_W-1:0] acc_reg    [bts_pkg::NUM_CH];
    logic [bts_pkg::ACC_W-1:0] total      [bts_pkg::NUM_CH];

    // Result queue.
    bts_pkg::result_t                 fifo_mem [bts_pkg::RESULT_DEPTH];
    logic [bts_pkg::RESULT_PTR_W-1:0] wr_ptr_reg;
    logic [bts_pkg::RESULT_PTR_W-1:0] rd_ptr_reg;
    logic [bts_pkg::CREDIT_W-1:0]     count_reg;
    logic [bts_pkg::CREDIT_W-1:0]     count_next;
    bts_pkg::result_t                 result;
    bts_pkg::result_t                 head;
    logic                             push;
    logic                             pop;

    // Weight each texel along x as its read data arrives.
    always_comb
    begin
        for (int c = 0; c < bts_pkg::NUM_CH; c++)
        begin
            prodx[c] = bts_pkg::ROW_W'(
                PRODX_W'(mem_rdata[c*bts_pkg::CHAN_W +: bts_pkg::CHAN_W])
                * PRODX_W'(t1_reg.wx));
        end
    end

    // Weight each row sum along y.
    always_comb
    begin
        for (int c = 0; c < bts_pkg::NUM_CH; c++)
        begin
            prody[c] = bts_pkg::ACC_W'(rowsum_reg[c]) * bts_pkg::ACC_W'(t3_reg.wy);
        end
    end

    // Only the second texel of a row, or a token without blending, goes on.
    assign t3_valid_next = t2_valid_reg && (!t2_reg.blend || t2_reg.col);

    // Final sum and the queued result.
    always_comb
    begin
        for (int c = 0; c < bts_pkg::NUM_CH; c++)
        begin
            total[c] = acc_reg[c] + py_reg[c];
        end
        result        = '0;
        result.status = t4_reg.status;
        if (t4_reg.blend)
        begin
            result.red   = total[CH_RED][bts_pkg::OUT_LSB +: bts_pkg::SAMPLE_W];
            result.green = total[CH_GREEN][bts_pkg::OUT_LSB +: bts_pkg::SAMPLE_W];
            result.blue  = total[CH_BLUE][bts_pkg::OUT_LSB +: bts_pkg::SAMPLE_W];
        end
    end

    assign push = t4_valid_reg && t4_reg.last;
    assign pop  = rsp_valid && !rsp_stall;

    assign count_next = count_reg + bts_pkg::CREDIT_W'(push) - bts_pkg::CREDIT_W'(pop);

    // Pipeline valid bits and queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
            t4_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            t1_valid_reg <= token_valid;
            t2_valid_reg <= t1_valid_reg;
            t3_valid_reg <= t3_valid_next;
            t4_valid_reg <= t3_valid_reg;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + bts_pkg::RESULT_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + bts_pkg::RESULT_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        t1_reg <= token;
        t2_reg <= t1_reg;
        px_reg <= prodx;
        if (t3_valid_next)
        begin
            t3_reg <= t2_reg;
        end
        t4_reg <= t3_reg;
        py_reg <= prody;
        for (int c = 0; c < bts_pkg::NUM_CH; c++)
        begin
            if (t2_valid_reg && t2_reg.blend && !t2_reg.col)
            begin
                rowacc_reg[c] <= px_reg[c];
            end
            if (t3_valid_next)
            begin
                rowsum_reg[c] <= rowacc_reg[c] + px_reg[c];
            end
            if (t4_valid_reg && t4_reg.blend && !t4_reg.row)
            begin
                acc_reg[c] <= py_reg[c];
            end
        end
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= result;
        end
    end

    // Output transaction from the head of the queue.
    assign head         = fifo_mem[rd_ptr_reg];
    assign rsp_valid    = count_reg != '0;
    assign sample_red   = head.red;
    assign sample_green = head.green;
    assign sample_blue  = head.blue;
    assign status       = head.status;
    assign rsp_done     = pop;

`ifndef SYNTHESIS
    // The sequencer's credit keeps the queue from overflowing.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < bts_pkg::CREDIT_W'(bts_pkg::RESULT_DEPTH)
                  || pop))
    else $error("result queue overflow");

    // A blended result closes on the far corner neighbor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && t4_reg.blend) |-> (t4_reg.row && t4_reg.col))
    else $error("blended result taken before its last neighbor");
`endif

endmodule
`default_nettype wire

[src/bilinear_texture_sampler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear texture sampler
// Texel store with write requests and bilinearly blended sample requests.
// ----------------------------------------------------------------------------
// Each request transaction yields exactly one result transaction, in order. A
// texel write, or any request rejected with an error status, is issued as a
// single token, and only a write inside the texture uses the texel memory
// port; a sample issues its four neighbor reads one after another and holds
// the port until they are done. Writes sustain one per cycle while the result
// queue has room. The texel memory is a single-port 64K x 24 RAM. Texels are
// stored at row * 256 + column and hold no defined value until written;
// changing the size registers does not move them. Size writes are taken at
// once (cfg_ready stays high) and should be made only while no transaction is
// in flight.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [bts_pkg::SIZE_W-1:0]          cfg_data,
    input  wire logic                                req_valid,
    output logic                                     req_stall,
    input  wire logic                                req_type,
    input  wire logic [bts_pkg::XW-1:0]              texel_x,
    input  wire logic [bts_pkg::YW-1:0]              texel_y,
    input  wire logic [bts_pkg::CHAN_W-1:0]          texel_red,
    input  wire logic [bts_pkg::CHAN_W-1:0]          texel_green,
    input  wire logic [bts_pkg::CHAN_W-1:0]          texel_blue,
    input  wire logic signed [bts_pkg::COORD_W-1:0]  coord_u,
    input  wire logic signed [bts_pkg::COORD_W-1:0]  coord_v,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_stall,
    output logic [bts_pkg::SAMPLE_W-1:0]             sample_red,
    output logic [bts_pkg::SAMPLE_W-1:0]             sample_green,
    output logic [bts_pkg::SAMPLE_W-1:0]             sample_blue,
    output logic [bts_pkg::STATUS_W-1:0]             status
);

    logic                          job_valid;
    bts_pkg::job_t                 job;
    logic                          job_take;
    logic                          rsp_done;
    logic                          mem_en;
    logic                          mem_we;
    logic [bts_pkg::ADDR_W-1:0]    mem_addr;
    logic [bts_pkg::TEXEL_W-1:0]   mem_wdata;
    logic [bts_pkg::TEXEL_W-1:0]   mem_rdata;
    logic                          token_valid;
    bts_pkg::token_t               token;

    // Size writes are always taken.
    assign cfg_ready = 1'b1;

    // Request decode and coordinate scaling.
    bts_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .texel_x     (texel_x),
        .texel_y     (texel_y),
        .texel_red   (texel_red),
        .texel_green (texel_green),
        .texel_blue  (texel_blue),
        .coord_u     (coord_u),
        .coord_v     (coord_v),
        .job_valid   (job_valid),
        .job         (job),
        .job_take    (job_take)
    );

    // Memory sequencer.
    bts_issue u_issue (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job         (job),
        .job_take    (job_take),
        .rsp_done    (rsp_done),
        .mem_en      (mem_en),
        .mem_we      (mem_we),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata),
        .token_valid (token_valid),
        .token       (token)
    );

    // Texel store.
    bts_ram #(
        .WIDTH (bts_pkg::TEXEL_W),
        .DEPTH (bts_pkg::TEX_DEPTH)
    ) u_texel_ram (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Blend pipeline and result queue.
    bts_blend u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .token_valid  (token_valid),
        .token        (token),
        .mem_rdata    (mem_rdata),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .sample_red   (sample_red),
        .sample_green (sample_green),
        .sample_blue  (sample_blue),
        .status       (status),
        .rsp_done     (rsp_done)
    );

endmodule
`default_nettype wire

[tb/bts_result_checker.sv]
// ----------------------------------------------------------------------------
// Bilinear texture sampler result checker
// Watches the size register, request and result channels of the sampler. It
// keeps its own texel store and size registers, works out the result of every
// accepted request and compares each result transaction, field by field, with
// the oldest result still owed.
// ----------------------------------------------------------------------------
module bts_result_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    input  wire logic                                cfg_ready,
    input  wire logic [bts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [bts_pkg::SIZE_W-1:0]          cfg_data,
    input  wire logic                                req_valid,
    input  wire logic                                req_stall,
    input  wire logic                                req_type,
    input  wire logic [bts_pkg::XW-1:0]              texel_x,
    input  wire logic [bts_pkg::YW-1:0]              texel_y,
    input  wire logic [bts_pkg::CHAN_W-1:0]          texel_red,
    input  wire logic [bts_pkg::CHAN_W-1:0]          texel_green,
    input  wire logic [bts_pkg::CHAN_W-1:0]          texel_blue,
    input  wire logic signed [bts_pkg::COORD_W-1:0]  coord_u,
    input  wire logic signed [bts_pkg::COORD_W-1:0]  coord_v,
    input  wire logic                                rsp_valid,
    input  wire logic                                rsp_stall,
    input  wire logic [bts_pkg::SAMPLE_W-1:0]        sample_red,
    input  wire logic [bts_pkg::SAMPLE_W-1:0]        sample_green,
    input  wire logic [bts_pkg::SAMPLE_W-1:0]        sample_blue,
    input  wire logic [bts_pkg::STATUS_W-1:0]        status,
    output int                                       mismatches,
    output int                                       outstanding
);
    import bts_pkg::*;

    localparam longint UNIT      = longint'(1) << FRAC_BITS;
    localparam int     SHIFT_OUT = 2 * FRAC_BITS - CHAN_W;

    // Shadow of the texel store, addressed as row * MAX_WIDTH + column.
    logic [TEXEL_W-1:0] texels [TEX_DEPTH];
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    result_t            owed_results [$];

    // A size of zero acts as one; anything above the maximum acts as the maximum.
    function automatic int unsigned span(input logic [SIZE_W-1:0] reg_val,
                                         input int unsigned limit);
        if (reg_val == '0)
            return 1;
        if (reg_val > limit)
            return limit;
        return reg_val;
    endfunction

    // Applies one request to the shadow store and returns the result it owes.
    function automatic result_t serve_request(
        input logic                        kind,
        input logic [XW-1:0]               col,
        input logic [YW-1:0]               row,
        input logic [TEXEL_W-1:0]          rgb,
        input logic signed [COORD_W-1:0]   u_in,
        input logic signed [COORD_W-1:0]   v_in
    );
        result_t             res;
        int unsigned         w;
        int unsigned         h;
        longint              su;
        longint              sv;
        longint unsigned     px;
        longint unsigned     py;
        longint unsigned     acc;
        longint unsigned     wx [2];
        longint unsigned     wy [2];
        int unsigned         xs [2];
        int unsigned         ys [2];
        logic [TEXEL_W-1:0]  nb [2][2];
        logic [SAMPLE_W-1:0] chans [NUM_CH];
        int                  i;
        int                  j;
        int                  ch;
        res = '0;
        w = span(width_reg, MAX_WIDTH);
        h = span(height_reg, MAX_HEIGHT);

        // Texel write: stored only when the address lies inside the texture.
        if (kind == REQ_WRITE) begin
            if (col >= w || row >= h)
                res.status = STATUS_ADDR;
            else
                texels[row * MAX_WIDTH + col] = rgb;
            return res;
        end

        su = u_in;
        sv = v_in;
        if (su < 0 || su > UNIT || sv < 0 || sv > UNIT) begin
            res.status = STATUS_COORD;
            return res;
        end

        // Scale to texel space; v is flipped so that row 0 is the top.
        px = su * (w - 1);
        py = (UNIT - sv) * (h - 1);
        xs[0] = px >> FRAC_BITS;
        ys[0] = py >> FRAC_BITS;
        wx[1] = px & (UNIT - 1);
        wy[1] = py & (UNIT - 1);
        wx[0] = UNIT - wx[1];
        wy[0] = UNIT - wy[1];
        // A zero fraction keeps the second neighbor on the first one.
        xs[1] = xs[0] + (wx[1] != 0);
        ys[1] = ys[0] + (wy[1] != 0);
        for (i = 0; i < 2; i++)
            for (j = 0; j < 2; j++)
                nb[i][j] = texels[ys[j] * MAX_WIDTH + xs[i]];

        // Exact blend of each byte, then truncation to Q8.8.
        for (ch = 0; ch < NUM_CH; ch++) begin
            acc = 0;
            for (i = 0; i < 2; i++)
                for (j = 0; j < 2; j++)
                    acc += nb[i][j][TEXEL_W-1-CHAN_W*ch -: CHAN_W] * wx[i] * wy[j];
            chans[ch] = acc >> SHIFT_OUT;
        end
        res.red    = chans[0];
        res.green  = chans[1];
        res.blue   = chans[2];
        res.status = STATUS_OK;
        return res;
    endfunction

    task automatic check_field(input string label, input logic [SAMPLE_W-1:0] want,
                               input logic [SAMPLE_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    // Results are checked before the request of the same edge is predicted, so a
    // result can never be matched against a request accepted at that very edge.
    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            width_reg  = SIZE_RESET;
            height_reg = SIZE_RESET;
            mismatches = 0;
            owed_results.delete();
            outstanding <= 0;
        end
        else begin
            // Size register write.
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end

            // Result transaction against the oldest owed result.
            if (rsp_valid && !rsp_stall) begin
                if (owed_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result transaction with none expected, got %0d %0d %0d %0d",
                             $time, sample_red, sample_green, sample_blue, status);
                end
                else begin
                    want = owed_results.pop_front();
                    check_field("sample_red", want.red, sample_red);
                    check_field("sample_green", want.green, sample_green);
                    check_field("sample_blue", want.blue, sample_blue);
                    check_field("status", want.status, status);
                end
            end

            // Request transaction.
            if (req_valid && !req_stall)
                owed_results.push_back(serve_request(req_type, texel_x, texel_y,
                                                     {texel_red, texel_green, texel_blue},
                                                     coord_u, coord_v));

            outstanding <= owed_results.size();
        end
    end

endmodule

[tb/tb_bilinear_texture_sampler.sv]
// ----------------------------------------------------------------------------
// Bilinear texture sampler testbench
// Drives texel writes and sample requests through a range of texture sizes,
// with random gaps on the request side and random stalls on the result side.
// Sample requests are only sent once all four texels they blend have been
// written. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_bilinear_texture_sampler;
    import bts_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 6;
    localparam int IDLE_LIMIT   = 5000;
    localparam int TAIL_CYCLES  = 20;
    localparam int PHASE_ITEMS  = 100;
    localparam int NUM_PHASES   = 10;
    localparam int UNIT         = 1 << FRAC_BITS;
    localparam int COORD_SPAN   = 1 << COORD_W;

    typedef struct {
        logic                        kind;
        logic [XW-1:0]               col;
        logic [YW-1:0]               row;
        logic [TEXEL_W-1:0]          rgb;
        logic signed [COORD_W-1:0]   u;
        logic signed [COORD_W-1:0]   v;
    } request_t;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        cfg_valid    = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index    = '0;
    logic [SIZE_W-1:0]           cfg_data     = '0;
    logic                        req_valid    = 1'b0;
    logic                        req_stall;
    logic                        req_type     = 1'b0;
    logic [XW-1:0]               texel_x      = '0;
    logic [YW-1:0]               texel_y      = '0;
    logic [CHAN_W-1:0]           texel_red    = '0;
    logic [CHAN_W-1:0]           texel_green  = '0;
    logic [CHAN_W-1:0]           texel_blue   = '0;
    logic signed [COORD_W-1:0]   coord_u      = '0;
    logic signed [COORD_W-1:0]   coord_v      = '0;
    logic                        rsp_valid;
    logic                        rsp_stall    = 1'b0;
    logic [SAMPLE_W-1:0]         sample_red;
    logic [SAMPLE_W-1:0]         sample_green;
    logic [SAMPLE_W-1:0]         sample_blue;
    logic [STATUS_W-1:0]         status;

    int  mismatches;
    int  outstanding;
    int  idle_cycles = 0;

    // Stimulus bookkeeping: texels written since reset and the sizes in effect.
    bit  written [TEX_DEPTH];
    int  cur_w = MAX_WIDTH;
    int  cur_h = MAX_HEIGHT;
    bit  steady = 1'b0;

    // Register values per random phase, extremes and out-of-range values included.
    int  phase_w [NUM_PHASES] = '{2, 0, 5, 511, 17, 256, 9, 300, 1, 33};
    int  phase_h [NUM_PHASES] = '{3, 5, 9, 4, 2, 256, 1, 0, 256, 64};

    bilinear_texture_sampler uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_type     (req_type),
        .texel_x      (texel_x),
        .texel_y      (texel_y),
        .texel_red    (texel_red),
        .texel_green  (texel_green),
        .texel_blue   (texel_blue),
        .coord_u      (coord_u),
        .coord_v      (coord_v),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .sample_red   (sample_red),
        .sample_green (sample_green),
        .sample_blue  (sample_blue),
        .status       (status)
    );

    bts_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_type     (req_type),
        .texel_x      (texel_x),
        .texel_y      (texel_y),
        .texel_red    (texel_red),
        .texel_green  (texel_green),
        .texel_blue   (texel_blue),
        .coord_u      (coord_u),
        .coord_v      (coord_v),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .sample_red   (sample_red),
        .sample_green (sample_green),
        .sample_blue  (sample_blue),
        .status       (status),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // Clock.
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Watchdog: ends the run after too many cycles without any transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("tb_bilinear_texture_sampler: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Mostly short gaps, a few long ones, none while steady is set.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    function automatic int span(input int reg_val, input int limit);
        if (reg_val == 0)
            return 1;
        if (reg_val > limit)
            return limit;
        return reg_val;
    endfunction

    // Every field random; callers overwrite the ones that matter.
    function automatic request_t noise_item();
        request_t it;
        it.kind = 1'($urandom);
        it.col  = XW'($urandom);
        it.row  = YW'($urandom);
        it.rgb  = TEXEL_W'($urandom);
        it.u    = COORD_W'($urandom);
        it.v    = COORD_W'($urandom);
        return it;
    endfunction

    // Result side: random stall bursts between runs of readiness.
    initial
    begin
        int run;
        int hold;
        @(posedge clk);
        forever
        begin
            rsp_stall <= 1'b0;
            run = $urandom_range(1, 8);
            repeat (run) @(posedge clk);
            hold = pick_gap();
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
        end
    end

    // One request transaction, held until accepted, then an optional gap.
    task automatic send(input request_t it);
        int gap;
        req_valid   <= 1'b1;
        req_type    <= it.kind;
        texel_x     <= it.col;
        texel_y     <= it.row;
        texel_red   <= it.rgb[23:16];
        texel_green <= it.rgb[15:8];
        texel_blue  <= it.rgb[7:0];
        coord_u     <= it.u;
        coord_v     <= it.v;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (it.kind == REQ_WRITE && it.col < cur_w && it.row < cur_h)
            written[{it.row, it.col}] = 1'b1;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic put_texel(input int x, input int y, input logic [TEXEL_W-1:0] rgb);
        request_t it;
        it      = noise_item();
        it.kind = REQ_WRITE;
        it.col  = XW'(x);
        it.row  = YW'(y);
        it.rgb  = rgb;
        send(it);
    endtask

    // Writes whatever part of the sample footprint is still unwritten, then
    // sends the sample itself.
    task automatic sample_at(input int u, input int v);
        request_t it;
        int       xs [2];
        int       ys [2];
        int       px;
        int       py;
        int       i;
        int       j;
        if (u >= 0 && u <= UNIT && v >= 0 && v <= UNIT)
        begin
            px = u * (cur_w - 1);
            py = (UNIT - v) * (cur_h - 1);
            xs[0] = px >> FRAC_BITS;
            ys[0] = py >> FRAC_BITS;
            xs[1] = xs[0] + ((px % UNIT) != 0);
            ys[1] = ys[0] + ((py % UNIT) != 0);
            for (i = 0; i < 2; i++)
                for (j = 0; j < 2; j++)
                    if (!written[ys[j] * MAX_WIDTH + xs[i]])
                        put_texel(xs[i], ys[j], TEXEL_W'($urandom));
        end
        it      = noise_item();
        it.kind = REQ_SAMPLE;
        it.u    = COORD_W'(u);
        it.v    = COORD_W'(v);
        send(it);
    endtask

    // Stops sending and waits until every owed result has come back.
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_size(input int wr, input int hr);
        drain();
        write_reg(CFG_WIDTH, SIZE_W'(wr));
        write_reg(CFG_HEIGHT, SIZE_W'(hr));
        cur_w = span(wr, MAX_WIDTH);
        cur_h = span(hr, MAX_HEIGHT);
    endtask

    // Random mix: writes, well-formed samples, grid-aligned samples, samples
    // with arbitrary coordinates, and now and then a full drain.
    task automatic random_phase(input int count);
        int n;
        int roll;
        int du;
        int dv;
        du = (cur_w > 1) ? cur_w - 1 : 1;
        dv = (cur_h > 1) ? cur_h - 1 : 1;
        for (n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
            begin
                if ($urandom_range(0, 3) == 0)
                    put_texel($urandom_range(0, 255), $urandom_range(0, 255),
                              TEXEL_W'($urandom));
                else
                    put_texel($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1),
                              TEXEL_W'($urandom));
            end
            else if (roll < 75)
                sample_at($urandom_range(0, UNIT), $urandom_range(0, UNIT));
            else if (roll < 86)
                sample_at($urandom_range(0, cur_w - 1) * UNIT / du,
                          $urandom_range(0, cur_h - 1) * UNIT / dv);
            else if (roll < 98)
                sample_at(int'($urandom_range(0, COORD_SPAN - 1)) - COORD_SPAN / 2,
                          int'($urandom_range(0, COORD_SPAN - 1)) - COORD_SPAN / 2);
            else
                drain();
        end
    endtask

    // Main sequence.
    initial
    begin
        int p;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset size: extreme colors and corners.
        put_texel(0, 0, 24'hFFFFFF);
        put_texel(1, 0, 24'h000000);
        put_texel(0, 1, 24'h80FF01);
        put_texel(1, 1, 24'h7F00FE);
        put_texel(255, 255, 24'hFF00FF);
        put_texel(255, 0, 24'h00FF00);
        // Exact texel at the top left, then the other three corners.
        sample_at(0, UNIT);
        sample_at(UNIT, 0);
        sample_at(0, 0);
        sample_at(UNIT, UNIT);
        // Largest fractions on both axes, then a plain blend.
        sample_at(257, UNIT - 257);
        sample_at(128, UNIT - 128);
        // Coordinates just outside and at the far ends of the field.
        sample_at(-1, 0);
        sample_at(UNIT + 1, 100);
        sample_at(0, -COORD_SPAN / 2);
        sample_at(COORD_SPAN / 2 - 1, COORD_SPAN / 2 - 1);
        sample_at(100, UNIT + 1);

        // Small texture: writes past the right and bottom edges are refused.
        set_size(3, 2);
        put_texel(3, 0, 24'h123456);
        put_texel(0, 2, 24'h654321);
        put_texel(255, 255, 24'hABCDEF);
        put_texel(2, 1, 24'h0F0F0F);
        sample_at(UNIT, UNIT);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            set_size(phase_w[p], phase_h[p]);
            steady = (p % 4 == 1);
            random_phase(PHASE_ITEMS);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_bilinear_texture_sampler: done, clean");
        else
            $display("tb_bilinear_texture_sampler: done, errors");
        $finish;
    end

endmodule

[files.f]
src/bts_pkg.sv
src/bts_ram.sv
src/bts_front.sv
src/bts_issue.sv
src/bts_blend.sv
src/bilinear_texture_sampler.sv
tb/bts_result_checker.sv
tb/tb_bilinear_texture_sampler.sv
